// File: src/tbp_pkg.sv
package tbp_pkg;

	localparam int NUM_CLASSES      = 7;
	localparam int TICKS_PER_SECOND = 1000000;
	localparam int NUM_REGS         = 7;

	localparam int CLASS_W   = 3;
	localparam int TS_W      = 32;
	localparam int RATE_W    = 24;
	localparam int BURST_W   = 16;
	localparam int REG_W     = RATE_W + BURST_W;
	localparam int CNT_W     = 32;
	localparam int CFG_IDX_W = 3;
	localparam int PROD_W    = TS_W + RATE_W;
	localparam int CLS_IDX_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

	localparam longint unsigned FULL_MAX =
		64'((2 ** BURST_W) - 1) * 64'(TICKS_PER_SECOND);
	localparam int BUCKET_W = $clog2(FULL_MAX + 64'd1);
	localparam int SUM_W    = ((PROD_W > BUCKET_W) ? PROD_W : BUCKET_W) + 1;

	localparam logic [BUCKET_W-1:0] TOKEN_ONE = BUCKET_W'(TICKS_PER_SECOND);

	localparam logic [REG_W-1:0] RST_FAST = REG_W'(65536100);
	localparam logic [REG_W-1:0] RST_SLOW = REG_W'(32768050);

	typedef logic [CLASS_W-1:0]   class_t;
	typedef logic [TS_W-1:0]      ts_t;
	typedef logic [RATE_W-1:0]    rate_t;
	typedef logic [BURST_W-1:0]   burst_t;
	typedef logic [REG_W-1:0]     reg_val_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [BUCKET_W-1:0]  bucket_t;
	typedef logic [CLS_IDX_W-1:0] cls_idx_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// per-class state as seen by the meter
	typedef struct packed {
		rate_t   rate;
		bucket_t cap;
		bucket_t bucket;
		ts_t     last;
		cnt_t    drops;
	} cls_state_t;

	// state writeback from the meter
	typedef struct packed {
		logic     en;
		cls_idx_t idx;
		bucket_t  bucket;
		ts_t      last;
		cnt_t     drops;
	} cls_upd_t;

	function automatic bucket_t full_bucket(input burst_t burst);
		return BUCKET_W'(BUCKET_W'(burst) * TOKEN_ONE);
	endfunction

	function automatic reg_val_t class_reset(input int c);
		if (c == 2 || c == 5 || c == 6)
			return RST_SLOW;
		return RST_FAST;
	endfunction

	function automatic rate_t class_reset_rate(input int c);
		reg_val_t v;
		v = class_reset(c);
		return v[REG_W-1:BURST_W];
	endfunction

	function automatic burst_t class_reset_burst(input int c);
		reg_val_t v;
		v = class_reset(c);
		return v[BURST_W-1:0];
	endfunction

	function automatic logic class_in_range(input class_t cls);
		return 32'(cls) < 32'(NUM_CLASSES);
	endfunction

endpackage

// File: src/tbp_if.sv
interface tbp_pkt_if import tbp_pkg::*; ();
	logic   valid;
	logic   ready;
	class_t traffic_class;
	ts_t    timestamp;

	modport source (output valid, traffic_class, timestamp, input ready);
	modport sink (input valid, traffic_class, timestamp, output ready);
endinterface

interface tbp_res_if import tbp_pkg::*; ();
	logic valid;
	logic ready;
	logic allowed;
	cnt_t policed_total;

	modport source (output valid, allowed, policed_total, input ready);
	modport sink (input valid, allowed, policed_total, output ready);
endinterface

interface tbp_cfg_if import tbp_pkg::*; ();
	logic     valid;
	logic     ready;
	cfg_idx_t index;
	reg_val_t data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: src/tbp_class_table.sv
module tbp_class_table import tbp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	tbp_cfg_if.sink    cfg,
	input  cls_idx_t   rd_idx,
	output cls_state_t rd_state,
	input  cls_upd_t   upd
);

	rate_t   rate_q   [NUM_CLASSES];
	bucket_t cap_q    [NUM_CLASSES];
	bucket_t bucket_q [NUM_CLASSES];
	ts_t     last_q   [NUM_CLASSES];
	cnt_t    drops_q  [NUM_CLASSES];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CLASSES; c++) begin
				rate_q[c]   <= class_reset_rate(c);
				cap_q[c]    <= full_bucket(class_reset_burst(c));
				bucket_q[c] <= full_bucket(class_reset_burst(c));
				last_q[c]   <= '0;
				drops_q[c]  <= '0;
			end
		end else begin
			for (int c = 0; c < NUM_CLASSES; c++) begin
				if (cfg.valid && c < NUM_REGS && int'(cfg.index) == c) begin
					rate_q[c]   <= cfg.data[REG_W-1:BURST_W];
					cap_q[c]    <= full_bucket(cfg.data[BURST_W-1:0]);
					bucket_q[c] <= full_bucket(cfg.data[BURST_W-1:0]);
				end else if (upd.en && upd.idx == CLS_IDX_W'(c)) begin
					bucket_q[c] <= upd.bucket;
					last_q[c]   <= upd.last;
					drops_q[c]  <= upd.drops;
				end
			end
		end
	end

	always_comb begin
		rd_state.rate   = rate_q[rd_idx];
		rd_state.cap    = cap_q[rd_idx];
		rd_state.bucket = bucket_q[rd_idx];
		rd_state.last   = last_q[rd_idx];
		rd_state.drops  = drops_q[rd_idx];
	end

endmodule

// File: src/tbp_meter.sv
module tbp_meter import tbp_pkg::*; (
	input  logic       go,
	input  class_t     cls,
	input  ts_t        now,
	input  cls_state_t st,
	output logic       allowed,
	output cnt_t       policed_total,
	output cls_upd_t   upd
);

	ts_t                elapsed;
	logic [PROD_W-1:0]  prod;
	logic [SUM_W-1:0]   sum;
	bucket_t            capped;
	logic               in_range;
	logic               pass;

	always_comb begin
		in_range = class_in_range(cls);
		elapsed  = now - st.last;
		prod     = PROD_W'(elapsed) * PROD_W'(st.rate);
		sum      = SUM_W'(st.bucket) + SUM_W'(prod);
		capped   = (sum > SUM_W'(st.cap)) ? st.cap : sum[BUCKET_W-1:0];
		pass     = capped >= TOKEN_ONE;

		upd.idx    = CLS_IDX_W'(cls);
		upd.last   = now;
		upd.bucket = pass ? capped - TOKEN_ONE : capped;
		upd.drops  = (pass || &st.drops) ? st.drops : st.drops + CNT_W'(1);
		upd.en     = go && in_range && (st.rate != '0);

		if (!in_range) begin
			allowed       = 1'b0;
			policed_total = '0;
		end else if (st.rate == '0) begin
			allowed       = 1'b1;
			policed_total = st.drops;
		end else begin
			allowed       = pass;
			policed_total = upd.drops;
		end
	end

endmodule

// File: src/per_class_token_bucket_policer.sv
// Per-class token bucket policer for punted packets.
// pkt: one request per packet (traffic_class, timestamp in ticks). res: one
// request per packet, in order (allowed, policed_total = saturating drop
// count of that class after this packet). cfg: write register i (class i
// rate in bits 39:16, burst in bits 15:0); a write refills that class's
// bucket. cfg.ready is always high; write only while no packet is in flight.
// Path: an accepted packet is held in the input register, then moves into the
// result register when it advances, and is taken from there by res.
// Throughput: one packet per cycle unless res stalls; input register, one
// 32x24 multiply with add/cap/compare and result register form the path.
// Classes at or above the class count give allowed 0, policed_total 0.
// Per-class state sits in flops and is updated as the packet moves into the
// result register, so back-to-back packets of one class see fresh state.
// Reset: all buckets full, timestamps and drop counts zero, registers at
// their defaults, no results pending.
// Stall: while res is stalled one more packet is held in the input
// register; pkt.ready then drops until the result is taken.
module per_class_token_bucket_policer import tbp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	tbp_pkt_if.sink  pkt,
	tbp_res_if.source res,
	tbp_cfg_if.sink  cfg
);

	logic       valid_s1;
	class_t     cls_s1;
	ts_t        ts_s1;
	logic       adv;
	cls_state_t st;
	cls_upd_t   upd;
	logic       allowed;
	cnt_t       policed;

	logic res_valid_q;
	logic allowed_q;
	cnt_t policed_q;

	assign adv       = valid_s1 && (!res_valid_q || res.ready);
	assign pkt.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (pkt.ready)
			valid_s1 <= pkt.valid;
	end

	always_ff @(posedge clk) begin
		if (pkt.valid && pkt.ready) begin
			cls_s1 <= pkt.traffic_class;
			ts_s1  <= pkt.timestamp;
		end
	end

	tbp_class_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.rd_idx   (CLS_IDX_W'(cls_s1)),
		.rd_state (st),
		.upd      (upd)
	);

	tbp_meter u_meter (
		.go            (adv),
		.cls           (cls_s1),
		.now           (ts_s1),
		.st            (st),
		.allowed       (allowed),
		.policed_total (policed),
		.upd           (upd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (adv)
			res_valid_q <= 1'b1;
		else if (res.ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			allowed_q <= allowed;
			policed_q <= policed;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.allowed       = allowed_q;
	assign res.policed_total = policed_q;

	a_adv_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> res.valid)
		else $error("advanced packet produced no result");

	a_hold_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && res.valid && !res.ready |-> !pkt.ready)
		else $error("input accepted while pipeline full");

	a_drop_counts: assert property (@(posedge clk) disable iff (!arst_n)
		adv && class_in_range(cls_s1) && !allowed |=> res.policed_total != '0)
		else $error("policed packet left zero drop count");

	a_out_of_range: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !class_in_range(cls_s1) |=> !res.allowed && res.policed_total == '0)
		else $error("out of range class gave nonzero result");

	a_no_upd_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |-> !upd.en)
		else $error("state written without a packet");

endmodule
